// ===== rtl/assert_macros.svh =====
// assertion helpers for the cipher checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under an active-low reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/aes192_pkg.sv =====
`default_nettype none
package aes192_pkg;

    localparam int NUM_ROUNDS = 12;
    localparam int RK_ENTRIES = NUM_ROUNDS + 1;
    localparam int RK_AW = $clog2(RK_ENTRIES);
    localparam int RK_WORDS = 4 * RK_ENTRIES;
    localparam int KEY_WORDS = 6;
    localparam int WIDX_W = $clog2(RK_WORDS);

    typedef logic [7:0] t_byte;
    typedef logic [255:0][7:0] t_tab;
    typedef logic [RK_AW-1:0] t_rk_addr;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY0 = 3'd0;
    localparam logic [2:0] CFG_KEY1 = 3'd1;
    localparam logic [2:0] CFG_KEY2 = 3'd2;
    localparam logic [2:0] CFG_IV_HI = 3'd3;
    localparam logic [2:0] CFG_IV_LO = 3'd4;
    localparam logic [2:0] CFG_MODE = 3'd5;

    // cipher modes
    localparam logic [2:0] MODE_ECB_ENC = 3'd0;
    localparam logic [2:0] MODE_ECB_DEC = 3'd1;
    localparam logic [2:0] MODE_CBC_ENC = 3'd2;
    localparam logic [2:0] MODE_CBC_DEC = 3'd3;
    localparam logic [2:0] MODE_CFB_ENC = 3'd4;
    localparam logic [2:0] MODE_CFB_DEC = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic busy;
    } t_ks_status;

    function automatic t_byte f_xt(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte f_gmul(input t_byte a, input t_byte b);
        t_byte acc;
        t_byte x;
        acc = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc = acc ^ x;
            x = f_xt(x);
        end
        return acc;
    endfunction

    function automatic t_byte f_ginv(input t_byte x);
        t_byte res;
        t_byte base;
        res = 8'h01;
        base = x;
        // x^254, exponent bits 1..7 set
        for (int k = 0; k < 8; k++) begin
            if (k != 0) res = f_gmul(res, base);
            base = f_gmul(base, base);
        end
        return res;
    endfunction

    function automatic t_byte f_rotl(input t_byte x, input int n);
        return t_byte'((x << n) | (x >> (8 - n)));
    endfunction

    function automatic t_tab f_build_sbox();
        t_tab t;
        t_byte v;
        for (int i = 0; i < 256; i++) begin
            v = f_ginv(t_byte'(i));
            t[i] = v ^ f_rotl(v, 1) ^ f_rotl(v, 2) ^ f_rotl(v, 3) ^ f_rotl(v, 4) ^ 8'h63;
        end
        return t;
    endfunction

    function automatic t_tab f_build_inv(input t_tab s);
        t_tab t;
        for (int i = 0; i < 256; i++) begin
            t[s[i]] = t_byte'(i);
        end
        return t;
    endfunction

    localparam t_tab SBOX = f_build_sbox();
    localparam t_tab INV_SBOX = f_build_inv(SBOX);

    function automatic logic [31:0] f_sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic t_byte f_get(input logic [127:0] s, input int i);
        return s[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] f_enc_round(input logic [127:0] s,
                                                 input logic [127:0] k,
                                                 input logic last);
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] m;
        for (int i = 0; i < 16; i++) begin
            a[127-8*i -: 8] = SBOX[f_get(s, i)];
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                b[127-8*(r+4*c) -: 8] = f_get(a, r + 4 * ((c + r) & 3));
            end
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                m[127-8*(4*c+r) -: 8] = f_xt(f_get(b, 4*c + r))
                    ^ f_xt(f_get(b, 4*c + ((r + 1) & 3))) ^ f_get(b, 4*c + ((r + 1) & 3))
                    ^ f_get(b, 4*c + ((r + 2) & 3)) ^ f_get(b, 4*c + ((r + 3) & 3));
            end
        end
        return (last ? b : m) ^ k;
    endfunction

    function automatic logic [127:0] f_dec_round(input logic [127:0] s,
                                                 input logic [127:0] k,
                                                 input logic last);
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] m;
        t_byte acc;
        t_byte coef [4];
        coef[0] = 8'd14;
        coef[1] = 8'd11;
        coef[2] = 8'd13;
        coef[3] = 8'd9;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                b[127-8*(r+4*((c+r)&3)) -: 8] = f_get(s, r + 4*c);
            end
        end
        for (int i = 0; i < 16; i++) begin
            a[127-8*i -: 8] = INV_SBOX[f_get(b, i)];
        end
        a = a ^ k;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++) begin
                    acc = acc ^ f_gmul(coef[(j - r + 4) & 3], f_get(a, 4*c + j));
                end
                m[127-8*(4*c+r) -: 8] = acc;
            end
        end
        return last ? a : m;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/aes192_key_sched.sv =====
`default_nettype none
module aes192_key_sched
    import aes192_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_key_wr,
    input  wire logic [191:0]   i_key,
    input  wire t_rk_addr       i_rd_addr,
    output logic      [127:0]   o_rd_data,
    output t_ks_status          o_status
);

    logic [127:0] r_rk_mem [RK_ENTRIES];
    logic               r_start;
    logic               r_run;
    logic [WIDX_W-1:0]  r_i;
    logic [2:0]         r_m6;
    t_byte              r_rc;
    logic [31:0]        r_win [KEY_WORDS];
    logic [95:0]        r_buf;
    logic [127:0]       r_rd;

    logic [31:0] key_word;
    logic [31:0] t_word;
    logic [31:0] new_word;

    always_comb begin
        case (r_i[2:0])
            3'd0:    key_word = i_key[191:160];
            3'd1:    key_word = i_key[159:128];
            3'd2:    key_word = i_key[127:96];
            3'd3:    key_word = i_key[95:64];
            3'd4:    key_word = i_key[63:32];
            default: key_word = i_key[31:0];
        endcase
        t_word = r_win[KEY_WORDS-1];
        if (r_m6 == 3'd0) begin
            t_word = f_sub_word({t_word[23:0], t_word[31:24]}) ^ {r_rc, 24'h000000};
        end
        if (r_i < WIDX_W'(KEY_WORDS)) begin
            new_word = key_word;
        end else begin
            new_word = r_win[0] ^ t_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
            r_run   <= 1'b0;
            r_i     <= '0;
            r_m6    <= '0;
            r_rc    <= 8'h01;
        end else begin
            r_start <= i_key_wr;
            if (r_start) begin
                // restart from the current key registers
                r_run <= 1'b1;
                r_i   <= '0;
                r_m6  <= '0;
                r_rc  <= 8'h01;
            end else if (r_run) begin
                r_i  <= r_i + 1'b1;
                r_m6 <= (r_m6 == 3'(KEY_WORDS - 1)) ? 3'd0 : r_m6 + 3'd1;
                if (r_m6 == 3'd0 && r_i >= WIDX_W'(KEY_WORDS)) r_rc <= f_xt(r_rc);
                if (r_i == WIDX_W'(RK_WORDS - 1)) r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run && !r_start) begin
            for (int j = 0; j < KEY_WORDS - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[KEY_WORDS-1] <= new_word;
            r_buf <= {r_buf[63:0], new_word};
            if (r_i[1:0] == 2'd3) begin
                r_rk_mem[r_i[WIDX_W-1:2]] <= {r_buf, new_word};
            end
        end
        r_rd <= r_rk_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
    assign o_status.busy = r_start | r_run;

endmodule
`default_nettype wire

// ===== rtl/aes192_core.sv =====
`default_nettype none
module aes192_core
    import aes192_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_ks_status     i_ks,
    input  wire logic [127:0]   i_iv,
    input  wire logic [2:0]     i_mode,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic [127:0]   i_block,
    input  wire logic           i_first,
    output t_rk_addr            o_rd_addr,
    input  wire logic [127:0]   i_rk,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic      [127:0]   o_result
);

    t_state       r_state;
    t_state       n_state;
    logic [3:0]   r_rnd;
    logic [2:0]   r_mode;
    logic [127:0] r_blk;
    logic [127:0] r_c;
    logic [127:0] r_dat;
    logic [127:0] r_chain;
    logic         r_out_valid;
    logic [127:0] r_res;

    logic         in_acc;
    logic         out_free;
    logic         fin;
    logic         dec_in;
    logic         dec;
    logic         last;
    logic [127:0] c_sel;
    logic [127:0] res;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign dec_in   = (i_mode == MODE_ECB_DEC) || (i_mode == MODE_CBC_DEC);
    assign dec      = (r_mode == MODE_ECB_DEC) || (r_mode == MODE_CBC_DEC);
    assign last     = (r_rnd == 4'(NUM_ROUNDS));
    assign c_sel    = i_first ? i_iv : r_chain;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_INIT;
            ST_INIT:  n_state = ST_ROUND;
            ST_ROUND: if (last) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = i_ks.busy || (r_state != ST_IDLE);
        fin        = (r_state == ST_DONE) && out_free;
        // key address for the next cycle's key add or round
        case (r_state)
            ST_IDLE:  o_rd_addr = dec_in ? t_rk_addr'(NUM_ROUNDS) : '0;
            ST_INIT:  o_rd_addr = dec ? t_rk_addr'(NUM_ROUNDS - 1) : t_rk_addr'(1);
            ST_ROUND: begin
                if (last) begin
                    o_rd_addr = '0;
                end else begin
                    o_rd_addr = dec ? t_rk_addr'(4'(NUM_ROUNDS - 1) - r_rnd)
                                    : t_rk_addr'(r_rnd + 4'd1);
                end
            end
            default:  o_rd_addr = '0;
        endcase
        case (r_mode)
            MODE_ECB_ENC, MODE_ECB_DEC, MODE_CBC_ENC: res = r_dat;
            MODE_CBC_DEC:                             res = r_dat ^ r_c;
            MODE_CFB_ENC, MODE_CFB_DEC:               res = r_dat ^ r_blk;
            default:                                  res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain     <= '0;
            r_out_valid <= 1'b0;
            r_rnd       <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc && i_first) r_chain <= i_iv;
            if (r_state == ST_INIT) r_rnd <= 4'd1;
            else if (r_state == ST_ROUND) r_rnd <= r_rnd + 4'd1;
            if (fin) begin
                r_out_valid <= 1'b1;
                case (r_mode)
                    MODE_CBC_ENC, MODE_CFB_ENC: r_chain <= res;
                    MODE_CBC_DEC, MODE_CFB_DEC: r_chain <= r_blk;
                    default:                    r_chain <= r_chain;
                endcase
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_blk  <= i_block;
            r_c    <= c_sel;
            case (i_mode)
                MODE_CBC_ENC:               r_dat <= i_block ^ c_sel;
                MODE_CFB_ENC, MODE_CFB_DEC: r_dat <= c_sel;
                default:                    r_dat <= i_block;
            endcase
        end else if (r_state == ST_INIT) begin
            r_dat <= r_dat ^ i_rk;
        end else if (r_state == ST_ROUND) begin
            r_dat <= dec ? f_dec_round(r_dat, i_rk, last) : f_enc_round(r_dat, i_rk, last);
        end
        if (fin) r_res <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_res;

endmodule
`default_nettype wire

// ===== rtl/aes192_block_cipher_modes.sv =====
// aes-192 in ecb, cbc and cfb-128, one shared round unit over a round key ram
// a request runs the init key add, then the rounds, then waits in done until the output is free
// a new request is taken only once the last is done, after the 12 rounds plus key add
// through the single round unit and the registered key ram read
// key write: schedule rebuilds 52 words, input stalled while it runs
// reset: synchronous active low, clears config, chain and control state
`default_nettype none
module aes192_block_cipher_modes
    import aes192_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [63:0] i_block_high,
    input  wire logic [63:0] i_block_low,
    input  wire logic        i_first_block,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [63:0] o_result_high,
    output logic      [63:0] o_result_low
);

    logic [63:0] r_key0;
    logic [63:0] r_key1;
    logic [63:0] r_key2;
    logic [63:0] r_iv_hi;
    logic [63:0] r_iv_lo;
    logic [2:0]  r_mode;

    logic         key_wr;
    t_ks_status   ks;
    t_rk_addr     rd_addr;
    logic [127:0] rk;
    logic [127:0] result;

    assign key_wr = i_cfg_we &&
        (i_cfg_idx == CFG_KEY0 || i_cfg_idx == CFG_KEY1 || i_cfg_idx == CFG_KEY2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0  <= '0;
            r_key1  <= '0;
            r_key2  <= '0;
            r_iv_hi <= '0;
            r_iv_lo <= '0;
            r_mode  <= MODE_ECB_ENC;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY0:  r_key0  <= i_cfg_data;
                CFG_KEY1:  r_key1  <= i_cfg_data;
                CFG_KEY2:  r_key2  <= i_cfg_data;
                CFG_IV_HI: r_iv_hi <= i_cfg_data;
                CFG_IV_LO: r_iv_lo <= i_cfg_data;
                CFG_MODE:  r_mode  <= i_cfg_data[2:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    aes192_key_sched u_ks (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key_wr  (key_wr),
        .i_key     ({r_key0, r_key1, r_key2}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rk),
        .o_status  (ks)
    );

    aes192_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ks        (ks),
        .i_iv        ({r_iv_hi, r_iv_lo}),
        .i_mode      (r_mode),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_block     ({i_block_high, i_block_low}),
        .i_first     (i_first_block),
        .o_rd_addr   (rd_addr),
        .i_rk        (rk),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_result_high = result[127:64];
    assign o_result_low  = result[63:0];

endmodule
`default_nettype wire

// ===== rtl/aes192_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module aes192_checker
    import aes192_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cfg_we,
    input wire logic [2:0]  i_cfg_idx,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [63:0] o_result_high,
    input wire logic [63:0] o_result_low
);

    logic in_acc;
    logic key_wr;

    assign in_acc = i_in_valid && !o_in_stall;
    assign key_wr = i_cfg_we &&
        (i_cfg_idx == CFG_KEY0 || i_cfg_idx == CFG_KEY1 || i_cfg_idx == CFG_KEY2);

    // a waiting result holds
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_result_high) && $stable(o_result_low))
    // one request at a time
    `AST_NEXT(a_acc_busy, i_clk, i_rst_n, in_acc, o_in_stall)
    // key rebuild blocks requests
    `AST_NEXT(a_key_busy, i_clk, i_rst_n, key_wr, o_in_stall)
    // no result can appear in the cycle right after a request
    `AST_SAME(a_no_early, i_clk, i_rst_n, $past(in_acc) && !$past(o_out_valid),
        !o_out_valid)

endmodule

bind aes192_block_cipher_modes aes192_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_result_high (o_result_high),
    .o_result_low  (o_result_low)
);
`default_nettype wire
